// ----- sv/cwce_pkg.sv -----
`default_nettype none
package cwce_pkg;

  localparam int DIGEST_DEPTH      = 16;
  localparam int MAX_ACKS_PER_ITEM = 15;
  localparam int PTR_W   = (DIGEST_DEPTH > 1) ? $clog2(DIGEST_DEPTH) : 1;
  localparam int CNT_W   = $clog2(DIGEST_DEPTH + 1);
  localparam int ACK_W   = $clog2(MAX_ACKS_PER_ITEM + 1);
  localparam int WIN_W   = 12;
  localparam int DIVC_W  = $clog2(WIN_W + 1);

  localparam logic [1:0] OP_PACKAGED = 2'd0;
  localparam logic [1:0] OP_RECEIVED = 2'd1;
  localparam logic [1:0] OP_ACK      = 2'd2;

  localparam logic [2:0] ERR_OK          = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd1;
  localparam logic [2:0] ERR_UNSUPPORTED = 3'd2;
  localparam logic [2:0] ERR_TOO_OLD     = 3'd3;
  localparam logic [2:0] ERR_NO_DIGEST   = 3'd4;
  localparam logic [2:0] ERR_MISMATCH    = 3'd5;
  localparam logic [2:0] ERR_STORE_FULL  = 3'd6;

  localparam logic [2:0] REG_IS_ORIGIN     = 3'd0;
  localparam logic [2:0] REG_WINDOW_START  = 3'd1;
  localparam logic [2:0] REG_WINDOW_INC    = 3'd2;
  localparam logic [2:0] REG_WINDOW_CEIL   = 3'd3;
  localparam logic [2:0] REG_ACCEPT_MIN    = 3'd4;
  localparam logic [2:0] REG_EMIT_MIN      = 3'd5;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 12'd1000;

  typedef struct packed {
    logic [1:0]  operation;
    logic        has_payload;
    logic [7:0]  payload_version;
    logic [63:0] digest_high;
    logic [63:0] digest_middle;
    logic [31:0] digest_low;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [11:0] window_value;
    logic        ack_version;
    logic [63:0] ack_digest_high;
    logic [63:0] ack_digest_middle;
    logic [31:0] ack_digest_low;
    logic [2:0]  error_code;
    logic        close_circuit;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        is_origin;
    logic [11:0] window_start;
    logic [11:0] window_increment;
    logic [11:0] window_ceiling;
    logic [7:0]  accept_min_version;
    logic [7:0]  emit_min_version;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_DIV, S_PKG, S_RX, S_ACK, S_STAT
  } state_t;

  typedef struct packed {
    logic load;
    logic dispatch;
    logic div_start;
    logic pkg;
    logic rx_ack;
    logic rx_status;
    logic ack;
    logic stat;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       need_div;
    logic       div_busy;
    logic       rx_more;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- sv/circuit_window_credit_engine.sv -----
`default_nettype none
// channel   direction  handshake                  payload
// cell      in         cell_valid / cell_stall    in_item_t (cell_data)
// result    out        result_valid / result_stall out_item_t
// apb       in         psel penable pwrite pready config registers at 4*index
//
// One item at a time. Data received emits one result per acknowledgement
// and then a status result. Data packaged runs the remainder check, when
// it applies, on a 12-step serial divider. A stalled result holds the
// engine in its final state.
// Reset sets both windows to 1000, empties the digest FIFO, config to defaults.
module circuit_window_credit_engine
  import cwce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cell_valid,
  output logic        cell_stall,
  input  in_item_t    cell_data,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    wr_en;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.is_origin          <= 1'b0;
      cfg.window_start       <= 12'd1000;
      cfg.window_increment   <= 12'd100;
      cfg.window_ceiling     <= 12'd1000;
      cfg.accept_min_version <= 8'd0;
      cfg.emit_min_version   <= 8'd0;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_IS_ORIGIN:    cfg.is_origin          <= pwdata[0];
        REG_WINDOW_START: cfg.window_start       <= pwdata[11:0];
        REG_WINDOW_INC:   cfg.window_increment   <= pwdata[11:0];
        REG_WINDOW_CEIL:  cfg.window_ceiling     <= pwdata[11:0];
        REG_ACCEPT_MIN:   cfg.accept_min_version <= pwdata[7:0];
        REG_EMIT_MIN:     cfg.emit_min_version   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_IS_ORIGIN:    prdata = {31'd0, cfg.is_origin};
      REG_WINDOW_START: prdata = {20'd0, cfg.window_start};
      REG_WINDOW_INC:   prdata = {20'd0, cfg.window_increment};
      REG_WINDOW_CEIL:  prdata = {20'd0, cfg.window_ceiling};
      REG_ACCEPT_MIN:   prdata = {24'd0, cfg.accept_min_version};
      REG_EMIT_MIN:     prdata = {24'd0, cfg.emit_min_version};
      default:          prdata = 32'd0;
    endcase
  end

  cwce_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .status     (status),
    .cmd        (cmd)
  );

  cwce_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cell_data    (cell_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

// ----- sv/cwce_ctrl.sv -----
`default_nettype none
module cwce_ctrl
  import cwce_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cell_valid,
  output logic    cell_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cell_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (status.op)
          OP_PACKAGED: state_next = status.need_div ? S_DIV : S_PKG;
          OP_RECEIVED: state_next = S_RX;
          OP_ACK:      state_next = S_ACK;
          default:     state_next = S_STAT;
        endcase
      end
      S_DIV: begin
        if (!status.div_busy) state_next = S_PKG;
      end
      S_RX: begin
        if (status.out_free && !status.rx_more) state_next = S_IDLE;
      end
      S_PKG, S_ACK, S_STAT: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cell_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        cell_stall = 1'b0;
        cmd.load   = cell_valid;
      end
      S_DISPATCH: begin
        cmd.dispatch  = 1'b1;
        cmd.div_start = (status.op == OP_PACKAGED) && status.need_div;
      end
      S_DIV: ;
      S_PKG:  cmd.pkg  = status.out_free;
      S_RX: begin
        cmd.rx_ack    = status.out_free && status.rx_more;
        cmd.rx_status = status.out_free && !status.rx_more;
      end
      S_ACK:  cmd.ack  = status.out_free;
      S_STAT: cmd.stat = status.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/cwce_dp.sv -----
`default_nettype none
module cwce_dp
  import cwce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_item_t  cell_data,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  in_item_t             item;
  logic [WIN_W-1:0]     send_window, receive_window;
  logic [PTR_W-1:0]     head, tail;
  logic [CNT_W-1:0]     count;
  logic [159:0]         mem [DIGEST_DEPTH];
  logic [159:0]         rd_data;
  logic                 div_busy;
  logic [DIVC_W-1:0]    div_cnt;
  logic [WIN_W-1:0]     div_a, div_rem;
  logic [ACK_W-1:0]     ack_cnt;

  logic [WIN_W:0]       trial, thresh, send_sum;
  logic                 need_div, store_full, record, rx_more, ack_ver;
  logic                 pop, mismatch, out_load;
  logic [7:0]           rx_ver;
  logic [2:0]           pkg_err, ack_err;
  logic [WIN_W-1:0]     send_after_pkg, send_after_ack, rx_sum;
  logic [159:0]         item_digest;
  out_item_t            out_next;

  assign item_digest = {item.digest_high, item.digest_middle, item.digest_low};
  assign need_div    = !cfg.is_origin && (cfg.window_increment != '0) && (send_window != '0);
  assign store_full  = (count >= CNT_W'(DIGEST_DEPTH));
  assign record      = need_div && (div_rem == '0);
  assign pkg_err     = (record && store_full) ? ERR_STORE_FULL : ERR_OK;
  assign send_after_pkg = (send_window != '0) ? send_window - 1'b1 : send_window;

  // restoring remainder, one quotient bit per cycle
  assign trial = {div_rem, div_a[WIN_W-1]};

  assign thresh  = {1'b0, cfg.window_start} - {1'b0, cfg.window_increment};
  assign rx_more = (ack_cnt < ACK_W'(MAX_ACKS_PER_ITEM)) &&
                   (cfg.window_increment <= cfg.window_start) &&
                   ({1'b0, receive_window} <= thresh);
  assign rx_sum  = receive_window + cfg.window_increment;
  assign ack_ver = (cfg.emit_min_version == 8'd1);

  assign rx_ver   = item.has_payload ? item.payload_version : 8'd0;
  assign mismatch = (rd_data != item_digest);
  assign send_sum = {1'b0, send_window} + {1'b0, cfg.window_increment};

  always_comb begin
    pop     = 1'b0;
    ack_err = ERR_OK;
    if (!cfg.is_origin) begin
      if (cfg.accept_min_version > 8'd1) begin
        ack_err = ERR_UNSUPPORTED;
      end else if (rx_ver < cfg.accept_min_version) begin
        ack_err = ERR_TOO_OLD;
      end else if (rx_ver == 8'd1) begin
        if (count == '0) begin
          ack_err = ERR_NO_DIGEST;
        end else begin
          pop = 1'b1;
          if (mismatch) ack_err = ERR_MISMATCH;
        end
      end
    end
    send_after_ack = send_window;
    if (ack_err == ERR_OK) begin
      if (send_sum > {1'b0, cfg.window_ceiling}) begin
        ack_err = ERR_OVERFLOW;
      end else begin
        send_after_ack = send_sum[WIN_W-1:0];
      end
    end
  end

  always_comb begin
    out_next = '0;
    out_next.last = 1'b1;
    if (cmd.pkg) begin
      out_next.window_value = send_after_pkg;
      out_next.error_code   = pkg_err;
    end else if (cmd.rx_ack) begin
      out_next.result_kind  = 1'b1;
      out_next.window_value = rx_sum;
      out_next.ack_version  = ack_ver;
      out_next.last         = 1'b0;
      if (ack_ver) begin
        out_next.ack_digest_high   = item.digest_high;
        out_next.ack_digest_middle = item.digest_middle;
        out_next.ack_digest_low    = item.digest_low;
      end
    end else if (cmd.rx_status) begin
      out_next.window_value = receive_window;
    end else if (cmd.ack) begin
      out_next.window_value = send_after_ack;
      out_next.error_code   = ack_err;
    end else begin
      out_next.window_value = send_window;
    end
    out_next.close_circuit = (out_next.error_code != ERR_OK);
  end

  assign out_load = cmd.pkg || cmd.rx_ack || cmd.rx_status || cmd.ack || cmd.stat;

  always_ff @(posedge clk) begin
    rd_data <= mem[head];
    if (cmd.pkg && record && !store_full) mem[tail] <= item_digest;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= cell_data;
    if (out_load) result <= out_next;
    if (cmd.div_start) begin
      div_a   <= send_window - 1'b1;
      div_rem <= '0;
    end else if (div_busy) begin
      div_a <= div_a << 1;
      if (trial >= {1'b0, cfg.window_increment}) begin
        div_rem <= WIN_W'(trial - {1'b0, cfg.window_increment});
      end else begin
        div_rem <= trial[WIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_window    <= WINDOW_RESET;
      receive_window <= WINDOW_RESET;
      head           <= '0;
      tail           <= '0;
      count          <= '0;
      div_busy       <= 1'b0;
      div_cnt        <= '0;
      ack_cnt        <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= DIVC_W'(WIN_W);
      end else if (div_busy) begin
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == DIVC_W'(1)) div_busy <= 1'b0;
      end
      if (cmd.dispatch) begin
        ack_cnt <= '0;
        if (item.operation == OP_RECEIVED && receive_window != '0) begin
          receive_window <= receive_window - 1'b1;
        end
      end
      if (cmd.rx_ack) begin
        receive_window <= rx_sum;
        ack_cnt        <= ack_cnt + 1'b1;
      end
      if (cmd.pkg) begin
        send_window <= send_after_pkg;
        if (record && !store_full) begin
          count <= count + 1'b1;
          tail  <= (tail == PTR_W'(DIGEST_DEPTH - 1)) ? '0 : tail + 1'b1;
        end
      end
      if (cmd.ack) begin
        send_window <= send_after_ack;
        if (pop) begin
          count <= count - 1'b1;
          head  <= (head == PTR_W'(DIGEST_DEPTH - 1)) ? '0 : head + 1'b1;
        end
      end
    end
  end

  assign status.op       = item.operation;
  assign status.need_div = need_div;
  assign status.div_busy = div_busy;
  assign status.rx_more  = rx_more;
  assign status.out_free = !result_valid || !result_stall;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import cwce_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cell_valid = 1'b0;
  logic        cell_stall;
  in_item_t    cell_data = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  circuit_window_credit_engine uut (
    .clk(clk), .rst(rst),
    .cell_valid(cell_valid), .cell_stall(cell_stall), .cell_data(cell_data),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  cfg_t        cfg;
  logic [11:0] send_win, recv_win;
  logic [159:0] digests [DIGEST_DEPTH];
  int unsigned fifo_head, fifo_count;
  out_item_t   expected_results [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  logic [159:0] sent_digests [$];

  function automatic out_item_t status_result(logic [11:0] win, logic [2:0] err);
    out_item_t r;
    r = '0;
    r.window_value = win;
    r.error_code = err;
    r.close_circuit = (err != ERR_OK);
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_credit(input in_item_t it);
    logic [2:0]  err;
    logic [7:0]  ver;
    logic [12:0] total;
    logic [159:0] dg;
    int          acks;
    out_item_t   r;
    err = ERR_OK;
    dg = {it.digest_high, it.digest_middle, it.digest_low};
    case (it.operation)
      OP_PACKAGED: begin
        if (!cfg.is_origin && cfg.window_increment != 0 && send_win != 0 &&
            ((send_win - 12'd1) % cfg.window_increment) == 0) begin
          if (fifo_count >= DIGEST_DEPTH) err = ERR_STORE_FULL;
          else begin
            digests[(fifo_head + fifo_count) % DIGEST_DEPTH] = dg;
            fifo_count++;
          end
        end
        if (send_win != 0) send_win = send_win - 12'd1;
        expected_results.push_back(status_result(send_win, err));
      end
      OP_RECEIVED: begin
        acks = 0;
        if (recv_win != 0) recv_win = recv_win - 12'd1;
        while (acks < MAX_ACKS_PER_ITEM && cfg.window_increment <= cfg.window_start &&
               recv_win <= cfg.window_start - cfg.window_increment) begin
          recv_win = recv_win + cfg.window_increment;
          r = '0;
          r.result_kind = 1'b1;
          r.window_value = recv_win;
          if (cfg.emit_min_version == 8'd1) begin
            r.ack_version = 1'b1;
            {r.ack_digest_high, r.ack_digest_middle, r.ack_digest_low} = dg;
          end
          expected_results.push_back(r);
          acks++;
        end
        expected_results.push_back(status_result(recv_win, ERR_OK));
      end
      OP_ACK: begin
        if (!cfg.is_origin) begin
          ver = it.has_payload ? it.payload_version : 8'd0;
          if (cfg.accept_min_version > 8'd1) err = ERR_UNSUPPORTED;
          else if (ver < cfg.accept_min_version) err = ERR_TOO_OLD;
          else if (ver == 8'd1) begin
            if (fifo_count == 0) err = ERR_NO_DIGEST;
            else begin
              if (digests[fifo_head] != dg) err = ERR_MISMATCH;
              fifo_head = (fifo_head + 1) % DIGEST_DEPTH;
              fifo_count--;
            end
          end
        end
        if (err == ERR_OK) begin
          total = {1'b0, send_win} + {1'b0, cfg.window_increment};
          if (total > {1'b0, cfg.window_ceiling}) err = ERR_OVERFLOW;
          else send_win = total[11:0];
        end
        expected_results.push_back(status_result(send_win, err));
      end
      default: expected_results.push_back(status_result(send_win, ERR_OK));
    endcase
  endtask

  // sender: bursts with random gaps; valid stays up within a burst
  task automatic send_cell(input in_item_t it);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
          cell_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 8);
      end
      burst_left--;
    end
    cell_data <= it;
    cell_valid <= 1'b1;
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    predict_credit(it);
  endtask

  task automatic wait_drained;
    cell_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_IS_ORIGIN:    cfg.is_origin = value[0];
      REG_WINDOW_START: cfg.window_start = value[11:0];
      REG_WINDOW_INC:   cfg.window_increment = value[11:0];
      REG_WINDOW_CEIL:  cfg.window_ceiling = value[11:0];
      REG_ACCEPT_MIN:   cfg.accept_min_version = value[7:0];
      REG_EMIT_MIN:     cfg.emit_min_version = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic org, input logic [11:0] st, inc, ceil,
                              input logic [7:0] acc, emit);
    write_reg(REG_IS_ORIGIN, {31'd0, org});
    write_reg(REG_WINDOW_START, {20'd0, st});
    write_reg(REG_WINDOW_INC, {20'd0, inc});
    write_reg(REG_WINDOW_CEIL, {20'd0, ceil});
    write_reg(REG_ACCEPT_MIN, {24'd0, acc});
    write_reg(REG_EMIT_MIN, {24'd0, emit});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic in_item_t make_item(input logic [1:0] op, input logic pay,
                                         input logic [7:0] ver,
                                         input logic [159:0] dg);
    in_item_t it;
    it.operation = op;
    it.has_payload = pay;
    it.payload_version = ver;
    {it.digest_high, it.digest_middle, it.digest_low} = dg;
    return it;
  endfunction

  function automatic logic [159:0] random_digest();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // packaged cells push digests; remember them to build matching acks
  task automatic send_packaged(input logic [159:0] dg);
    int unsigned before_count;
    before_count = fifo_count;
    send_cell(make_item(OP_PACKAGED, 1'($urandom_range(0, 1)), 8'($urandom), dg));
    if (fifo_count != before_count) sent_digests.push_back(dg);
  endtask

  task automatic send_matching_ack;
    logic [159:0] dg;
    dg = (sent_digests.size() != 0) ? sent_digests.pop_front() : random_digest();
    send_cell(make_item(OP_ACK, 1'b1, 8'd1, dg));
  endtask

  task automatic test_directed_defaults;
    // defaults: start 1000, inc 100; window 1000 is off the record point
    send_packaged({160{1'b1}});
    send_packaged('0);
    send_cell(make_item(OP_ACK, 1'b1, 8'd1, {160{1'b1}}));   // no digest
    send_cell(make_item(OP_ACK, 1'b1, 8'd1, {160{1'b1}}));   // no digest
    send_cell(make_item(OP_ACK, 1'b0, 8'hff, '0));
    send_cell(make_item(OP_ACK, 1'b1, 8'hff, random_digest()));
    send_cell(make_item(2'd3, 1'b1, 8'hff, {160{1'b1}}));
    repeat (3) send_cell(make_item(OP_RECEIVED, 1'b0, 8'd0, random_digest()));
    wait_drained();
  endtask

  task automatic test_small_windows;
    // start 20, inc 3: frequent digest records
    apply_config(1'b0, 12'd20, 12'd3, 12'd4095, 8'd1, 8'd1);
    repeat (25) send_packaged(random_digest());        // records a digest every third cell
    send_cell(make_item(OP_ACK, 1'b1, 8'd0, '0));       // too old
    send_cell(make_item(OP_ACK, 1'b1, 8'd1, random_digest())); // mismatch
    repeat (20) send_cell(make_item(OP_RECEIVED, 1'b1, 8'd1, random_digest()));
    wait_drained();
    apply_config(1'b0, 12'd4095, 12'd0, 12'd1, 8'd255, 8'd0);  // inc zero: cap
    send_cell(make_item(OP_RECEIVED, 1'b0, 8'd0, '0));
    send_cell(make_item(OP_PACKAGED, 1'b0, 8'd0, '0));
    send_cell(make_item(OP_ACK, 1'b1, 8'd1, '0));       // unsupported
    wait_drained();
    apply_config(1'b1, 12'd1, 12'd4095, 12'd4095, 8'd0, 8'd2); // inc above start
    send_cell(make_item(OP_RECEIVED, 1'b0, 8'd0, '0));
    send_cell(make_item(OP_ACK, 1'b1, 8'd1, random_digest()));
    send_cell(make_item(OP_PACKAGED, 1'b1, 8'd0, random_digest()));
    wait_drained();
  endtask

  task automatic test_random_traffic;
    int   phase, k, pick;
    logic [11:0] st;
    for (phase = 0; phase < 6; phase++) begin
      st = 12'($urandom_range(2, 60));
      sent_digests.delete();
      apply_config(phase == 5, st, 12'($urandom_range(1, st)),
                   12'($urandom_range(1, 4095)), 8'($urandom_range(0, 1)),
                   (phase % 2) ? 8'd1 : 8'($urandom_range(0, 255)));
      sent_digests.delete();
      // matching acks only while every store entry is a remembered digest
      for (k = 0; k < 45; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) send_packaged(random_digest());
        else if (pick < 60) send_cell(make_item(OP_RECEIVED, 1'($urandom_range(0, 1)),
                                                8'($urandom), random_digest()));
        else if (pick < 85 && fifo_count == sent_digests.size()) send_matching_ack();
        else send_cell(make_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 8'($urandom), random_digest()));
        if (k == 20 && phase == 2) begin
          cell_valid <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk);
          gaps_on = 1'b0;
        end
      end
      gaps_on = 1'b1;
      wait_drained();
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if ($urandom_range(0, 3) == 0) result_stall <= ($urandom_range(0, 2) == 0);
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item %p", result);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.result_kind != want.result_kind) begin
          $error("result_kind exp %0d got %0d", want.result_kind, result.result_kind);
          fail_count++;
        end
        if (result.window_value != want.window_value) begin
          $error("window_value exp %0d got %0d", want.window_value, result.window_value);
          fail_count++;
        end
        if (result.ack_version != want.ack_version) begin
          $error("ack_version exp %0d got %0d", want.ack_version, result.ack_version);
          fail_count++;
        end
        if (result.ack_digest_high != want.ack_digest_high) begin
          $error("ack_digest_high exp %h got %h", want.ack_digest_high,
                 result.ack_digest_high);
          fail_count++;
        end
        if (result.ack_digest_middle != want.ack_digest_middle) begin
          $error("ack_digest_middle exp %h got %h", want.ack_digest_middle,
                 result.ack_digest_middle);
          fail_count++;
        end
        if (result.ack_digest_low != want.ack_digest_low) begin
          $error("ack_digest_low exp %h got %h", want.ack_digest_low,
                 result.ack_digest_low);
          fail_count++;
        end
        if (result.error_code != want.error_code) begin
          $error("error_code exp %0d got %0d", want.error_code, result.error_code);
          fail_count++;
        end
        if (result.close_circuit != want.close_circuit) begin
          $error("close_circuit exp %0d got %0d", want.close_circuit,
                 result.close_circuit);
          fail_count++;
        end
        if (result.last != want.last) begin
          $error("last exp %0d got %0d", want.last, result.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item or register access
  always @(posedge clk) begin
    if ((cell_valid && !cell_stall) || (result_valid && !result_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("circuit_window_credit_engine test failed");
      $finish;
    end
  end

  initial begin
    cfg = '{is_origin: 1'b0, window_start: 12'd1000, window_increment: 12'd100,
            window_ceiling: 12'd1000, accept_min_version: 8'd0, emit_min_version: 8'd0};
    send_win = WINDOW_RESET;
    recv_win = WINDOW_RESET;
    fifo_head = 0;
    fifo_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_small_windows();
    test_random_traffic();
    if (fail_count == 0 && expected_results.size() == 0)
      $display("circuit_window_credit_engine test passed");
    else
      $display("circuit_window_credit_engine test failed");
    $finish;
  end

endmodule
